/* rtl/nonce_replay_filter_macros.svh */
// Assertion macros shared by the checker
`ifndef NONCE_REPLAY_FILTER_MACROS_SVH
`define NONCE_REPLAY_FILTER_MACROS_SVH
// clocked implication with reset disable
`define NRF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked also during reset
`define NRF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/nrf_pkg.sv */
// ----------------------------------------------------------------------------
// nrf_pkg
// Shared types and codes of the nonce replay filter.
// ----------------------------------------------------------------------------
package nrf_pkg;

  localparam int unsigned NonceW = 128;

  typedef logic [NonceW-1:0] nonce_t;

  typedef enum logic [1:0] {
    VerdictOk     = 2'd0,
    VerdictStale  = 2'd1,
    VerdictReplay = 2'd2,
    VerdictAuth   = 2'd3
  } verdict_e;

  localparam logic OpInit   = 1'b0;
  localparam logic OpScreen = 1'b1;

  localparam logic [0:0] RegRefresh = 1'd0;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic do_init;   // load both marks with the current time
    logic scan_rst;  // restart the history scan
    logic scan_adv;  // compare one entry, advance pointer
    logic commit;    // apply an acceptance
    logic clr_adv;   // clear one entry during the reset sweep
  } nrf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic auth;
    logic stale;
    logic hit;
    logic scan_last;
    logic clr_last;
  } nrf_sts_t;

endpackage

/* rtl/nrf_datapath.sv */
// ----------------------------------------------------------------------------
// nrf_datapath
// Marks, counter, history ring memory and the scan comparator.
// ----------------------------------------------------------------------------
module nrf_datapath #(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nrf_pkg::nrf_cmd_t cmd_i,
  output nrf_pkg::nrf_sts_t sts_o,
  input  logic [7:0]        refresh_interval_i,
  input  logic              operation_i,
  input  logic [63:0]       nonce_high_i,
  input  logic [63:0]       nonce_low_i,
  input  logic              auth_ok_i,
  input  logic [63:0]       time_high_i,
  input  logic [63:0]       time_low_i
);

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(HISTORY_DEPTH - 1);

  // ring memory: head_q points at the oldest entry
  nrf_pkg::nonce_t mem [HISTORY_DEPTH];
  nrf_pkg::nonce_t rd_q;

  logic [AW-1:0]   head_q, head_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [AW-1:0]   cnt_q, cnt_d;   // entries compared so far
  logic [AW-1:0]   clr_q;
  logic            hit_q;
  logic            rd_vld_q;
  logic [7:0]      acc_q;
  nrf_pkg::nonce_t low_q, pend_q, nonce_q, time_q;
  logic            op_q, auth_q;
  nrf_pkg::nonce_t low_ref;
  logic            refresh;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  nrf_pkg::nonce_t wr_data;

  assign refresh = (acc_q >= refresh_interval_i);
  assign low_ref = refresh ? pend_q : low_q;

  always_comb begin
    head_d = (head_q == LastIdx) ? '0 : head_q + AW'(1);
    ptr_d  = (ptr_q == LastIdx) ? '0 : ptr_q + AW'(1);
    cnt_d  = cnt_q + AW'(1);
  end

  always_comb begin
    wr_en   = cmd_i.clr_adv | cmd_i.commit;
    wr_addr = cmd_i.clr_adv ? clr_q : head_q;
    wr_data = cmd_i.clr_adv ? '0 : nonce_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      auth_q  <= auth_ok_i;
      nonce_q <= {nonce_high_i, nonce_low_i};
      time_q  <= {time_high_i, time_low_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      ptr_q    <= '0;
      cnt_q    <= '0;
      clr_q    <= '0;
      hit_q    <= 1'b0;
      rd_vld_q <= 1'b0;
      acc_q    <= '0;
      low_q    <= '0;
      pend_q   <= '0;
    end else begin
      if (cmd_i.clr_adv) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.do_init) begin
        low_q  <= time_q;
        pend_q <= time_q;
      end
      if (cmd_i.scan_rst) begin
        ptr_q    <= head_q;
        cnt_q    <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.scan_adv) begin
        // rd_q holds the entry that ptr_q addressed in the cycle before
        ptr_q    <= ptr_d;
        rd_vld_q <= 1'b1;
        if (rd_vld_q) begin
          cnt_q <= cnt_d;
        end
      end
      // the last compare lands in the same cycle as the scan restart
      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end else if (cmd_i.scan_adv && rd_vld_q && (rd_q == nonce_q)) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        // rd_q holds the oldest entry (scan restarted at head)
        if (refresh) begin
          pend_q <= time_q;
        end
        low_q  <= (low_ref < rd_q) ? rd_q : low_ref;
        acc_q  <= (refresh ? 8'd0 : acc_q) + 8'd1;
        head_q <= head_d;
      end
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.auth      = auth_q;
    sts_o.stale     = !(low_q < nonce_q);
    sts_o.hit       = hit_q;
    sts_o.scan_last = rd_vld_q && (cnt_q == LastIdx);
    sts_o.clr_last  = (clr_q == LastIdx);
  end

endmodule

/* rtl/nrf_ctrl.sv */
// ----------------------------------------------------------------------------
// nrf_ctrl
// Sequencer: reset sweep, capture, history scan, verdict and commit.
// ----------------------------------------------------------------------------
module nrf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        verdict_o,
  output nrf_pkg::nrf_cmd_t cmd_o,
  input  nrf_pkg::nrf_sts_t sts_i
);

  typedef enum logic [2:0] {
    StClear, StIdle, StCheck, StScan, StPrep, StCommit, StOut
  } state_e;

  state_e     state_q;
  logic       out_valid_q;
  logic [1:0] verdict_q;
  logic       accept;

  assign accept      = (state_q == StIdle) && in_valid_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.clr_adv  = (state_q == StClear);
    cmd_o.do_init  = (state_q == StCheck) && (sts_i.op == nrf_pkg::OpInit);
    cmd_o.scan_rst = (state_q == StCheck) || (state_q == StScan && sts_i.scan_last);
    cmd_o.scan_adv = (state_q == StScan) || (state_q == StPrep);
    cmd_o.commit   = (state_q == StCommit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
      verdict_q   <= nrf_pkg::VerdictOk;
    end else begin
      unique case (state_q)
        StClear: begin
          if (sts_i.clr_last) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StCheck;
          end
        end
        StCheck: begin
          priority if (sts_i.op == nrf_pkg::OpInit) begin
            verdict_q   <= nrf_pkg::VerdictOk;
            out_valid_q <= 1'b1;
            state_q     <= StOut;
          end else if (sts_i.stale) begin
            verdict_q   <= nrf_pkg::VerdictStale;
            out_valid_q <= 1'b1;
            state_q     <= StOut;
          end else begin
            state_q <= StScan;
          end
        end
        StScan: begin
          if (sts_i.scan_last) begin
            // hit_q already includes the last compare only next cycle
            state_q <= StPrep;
          end
        end
        StPrep: begin
          priority if (sts_i.hit) begin
            verdict_q   <= nrf_pkg::VerdictReplay;
            out_valid_q <= 1'b1;
            state_q     <= StOut;
          end else if (!sts_i.auth) begin
            verdict_q   <= nrf_pkg::VerdictAuth;
            out_valid_q <= 1'b1;
            state_q     <= StOut;
          end else begin
            state_q <= StCommit;
          end
        end
        StCommit: begin
          verdict_q   <= nrf_pkg::VerdictOk;
          out_valid_q <= 1'b1;
          state_q     <= StOut;
        end
        StOut: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

/* rtl/nonce_replay_filter.sv */
// ----------------------------------------------------------------------------
// nonce_replay_filter
// Anti-replay screen for 128-bit timestamp nonces with a history memory.
// ----------------------------------------------------------------------------
// Each item gives one verdict. An init item or a stale nonce is answered after
// the check, a replayed or unauthenticated nonce after the scan that reads one
// history entry per cycle from a memory with one read and one write port, and
// an accepted nonce after that scan and its commit. A stalled result holds, and
// the next item is taken only once the result has been taken. After reset a
// clearing pass zeroes the history while no item is accepted; configuration
// writes are taken throughout.
module nonce_replay_filter #(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [63:0] nonce_high_i,
  input  logic [63:0] nonce_low_i,
  input  logic        auth_ok_i,
  input  logic [63:0] time_high_i,
  input  logic [63:0] time_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  nrf_pkg::nrf_cmd_t cmd;
  nrf_pkg::nrf_sts_t sts;
  logic [7:0]        refresh_q;
  logic [0:0]        reg_idx;

  // paddr is the register index: only index 0 holds a register
  assign reg_idx = paddr;
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == nrf_pkg::RegRefresh) ? {24'd0, refresh_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_q <= 8'd32;
    end else if (psel && penable && pwrite && reg_idx == nrf_pkg::RegRefresh) begin
      refresh_q <= pwdata[7:0];
    end
  end

  nrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  nrf_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .refresh_interval_i (refresh_q),
    .operation_i        (operation_i),
    .nonce_high_i       (nonce_high_i),
    .nonce_low_i        (nonce_low_i),
    .auth_ok_i          (auth_ok_i),
    .time_high_i        (time_high_i),
    .time_low_i         (time_low_i)
  );

endmodule

/* rtl/nrf_checker.sv */
// ----------------------------------------------------------------------------
// nrf_checker
// Port-level checks of the nonce replay filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "nonce_replay_filter_macros.svh"

module nrf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] verdict_o
);

  // one item in flight: no intake while a result is pending
  `NRF_ASSERT(a_no_take_while_out, clk_i, rst_ni, out_valid_o |-> in_stall_o, "intake during result")
  // an accepted item never yields a result in the next cycle
  `NRF_ASSERT(a_latency, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> !out_valid_o, "result too early")
  // a stalled result holds
  `NRF_ASSERT(a_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(verdict_o)), "result dropped")
  // no result during reset
  `NRF_ASSERT_ALWAYS(a_reset, clk_i, !rst_ni |-> !out_valid_o, "result in reset")

endmodule

bind nonce_replay_filter nrf_checker u_nrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .verdict_o   (verdict_o)
);

/* bench/nonce_replay_filter_tb.sv */
// ----------------------------------------------------------------------------
// nonce_replay_filter_tb
// Self-checking bench for the nonce replay filter. A queue of items feeds a
// burst/gap driver. A verdict predictor runs on every accepted item, and a
// monitor with its own stall pattern compares each verdict in order. The
// refresh interval is rewritten between phases, and read back, while idle.
// ----------------------------------------------------------------------------
module nonce_replay_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HistDepth  = 128;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned LongHold   = 3000;

  typedef struct {
    logic            op;
    nrf_pkg::nonce_t nonce;
    logic            auth;
    nrf_pkg::nonce_t now;
  } pkt_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = nrf_pkg::OpInit;
  logic [63:0] nonce_high_i = '0;
  logic [63:0] nonce_low_i = '0;
  logic        auth_ok_i = 1'b0;
  logic [63:0] time_high_i = '0;
  logic [63:0] time_low_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  verdict_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nonce_replay_filter #(.HISTORY_DEPTH(HistDepth)) DUT (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  nrf_pkg::nonce_t   low_mark, pending_mark;
  nrf_pkg::nonce_t   history [HistDepth];
  logic [7:0]        accept_cnt, interval;

  pkt_t              pkt_queue[$];
  nrf_pkg::verdict_e verdict_queue[$];
  pkt_t              cur_pkt;
  int                errors = 0;

  // stimulus generation state
  nrf_pkg::nonce_t   sim_now;
  nrf_pkg::nonce_t   recent[$];

  task automatic report(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic nrf_pkg::verdict_e screen_pkt(input pkt_t p);
    if (p.op == nrf_pkg::OpInit) begin
      low_mark = p.now;
      pending_mark = p.now;
      return nrf_pkg::VerdictOk;
    end
    if (!(low_mark < p.nonce)) return nrf_pkg::VerdictStale;
    foreach (history[i]) if (history[i] == p.nonce) return nrf_pkg::VerdictReplay;
    if (!p.auth) return nrf_pkg::VerdictAuth;
    if (accept_cnt >= interval) begin
      low_mark = pending_mark;
      pending_mark = p.now;
      accept_cnt = '0;
    end
    if (low_mark < history[0]) low_mark = history[0];
    for (int i = 0; i < HistDepth - 1; i++) history[i] = history[i+1];
    history[HistDepth-1] = p.nonce;
    accept_cnt = accept_cnt + 8'd1;
    return nrf_pkg::VerdictOk;
  endfunction

  function automatic nrf_pkg::nonce_t rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic pkt_t make_pkt();
    pkt_t p;
    int   kind;
    kind = $urandom_range(0, 99);
    sim_now = sim_now + nrf_pkg::nonce_t'($urandom_range(1, 2000));
    p.op = nrf_pkg::OpScreen;
    p.now = sim_now;
    p.auth = ($urandom_range(0, 9) != 0);
    p.nonce = sim_now - nrf_pkg::nonce_t'($urandom_range(0, 500));
    if (kind < 60) begin
      recent.push_back(p.nonce);
      if (recent.size() > 16) void'(recent.pop_front());
    end else if (kind < 72) begin
      if (recent.size() > 0) p.nonce = recent[$urandom_range(0, recent.size() - 1)];
    end else if (kind < 80) begin
      p.nonce = sim_now - (nrf_pkg::nonce_t'(1) << $urandom_range(20, 100));
    end else if (kind < 84) begin
      p.op = nrf_pkg::OpInit;
      p.nonce = rand128();
      p.auth = 1'($urandom_range(0, 1));
    end else if (kind < 88) begin
      // rebase time to a random point so the high bits move too
      p.op = nrf_pkg::OpInit;
      sim_now = rand128() >> $urandom_range(0, 8);
      p.now = sim_now;
      p.nonce = rand128();
    end else begin
      p.nonce = rand128();
      p.auth = 1'($urandom_range(0, 1));
    end
    return p;
  endfunction

  function automatic pkt_t fixed_pkt(input logic op, input nrf_pkg::nonce_t n, input logic a,
                                     input nrf_pkg::nonce_t t);
    pkt_t p;
    p.op = op;
    p.nonce = n;
    p.auth = a;
    p.now = t;
    return p;
  endfunction

  // driver
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) verdict_queue.push_back(screen_pkt(cur_pkt));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pkt_queue.size() > 0) begin
          cur_pkt = pkt_queue.pop_front();
          operation_i <= cur_pkt.op;
          nonce_high_i <= cur_pkt.nonce[127:64];
          nonce_low_i <= cur_pkt.nonce[63:0];
          auth_ok_i <= cur_pkt.auth;
          time_high_i <= cur_pkt.now[127:64];
          time_low_i <= cur_pkt.now[63:0];
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_mode = 0, mode_left = 0, hold_left = 0, seen = 0;
  bit held_once = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen++;
        if (verdict_queue.size() == 0) begin
          report("unexpected verdict", verdict_o, -1);
        end else if (verdict_o !== verdict_queue[0]) begin
          report("verdict", verdict_o, verdict_queue[0]);
          void'(verdict_queue.pop_front());
        end else begin
          void'(verdict_queue.pop_front());
        end
      end
      if (!held_once && seen == 400) begin
        held_once = 1'b1;
        hold_left = LongHold;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 400);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 2) == 0);
          default: out_stall_i <= (mode_left % 7 < 4);
        endcase
      end
    end
  end

  // cycle limit
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pkt_queue.size() != 0 || verdict_queue.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (HistDepth + 10) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [7:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= nrf_pkg::RegRefresh;
    pwdata <= {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    interval = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== value) report("refresh_interval readback", prdata[7:0], value);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_random(input int count);
    @(negedge clk_i);
    repeat (count) pkt_queue.push_back(make_pkt());
  endtask

  initial begin
    logic [7:0]      settings [6];
    nrf_pkg::nonce_t ones;
    rst_ni <= 1'b0;
    ones = '1;
    low_mark = '0;
    pending_mark = '0;
    foreach (history[i]) history[i] = '0;
    accept_cnt = '0;
    interval = 8'd32;
    sim_now = nrf_pkg::nonce_t'(64'h1000) << 64;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_interval(8'd2);
    // directed: out of reset, extremes, replay, auth failure, inits at both extremes and at the current time
    @(negedge clk_i);
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, '0, 1'b1, '0));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, nrf_pkg::nonce_t'(1), 1'b1, '0));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, nrf_pkg::nonce_t'(1), 1'b1, '0));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, ones, 1'b0, ones));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, nrf_pkg::nonce_t'(2), 1'b1,
                                  nrf_pkg::nonce_t'(50)));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, nrf_pkg::nonce_t'(3), 1'b1,
                                  nrf_pkg::nonce_t'(60)));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, nrf_pkg::nonce_t'(100), 1'b1,
                                  nrf_pkg::nonce_t'(70)));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, nrf_pkg::nonce_t'(40), 1'b1,
                                  nrf_pkg::nonce_t'(80)));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, ones, 1'b1, ones));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, ones, 1'b1, ones));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpInit, ones, 1'b1, ones));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, ones, 1'b1, '0));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpInit, '0, 1'b0, '0));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpScreen, nrf_pkg::nonce_t'(5), 1'b1, '0));
    pkt_queue.push_back(fixed_pkt(nrf_pkg::OpInit, '1, 1'b1, sim_now));
    wait_drained();

    settings = '{8'd0, 8'd1, 8'd255, 8'd32, 8'd3, 8'($urandom_range(1, 255))};
    foreach (settings[s]) begin
      write_interval(settings[s]);
      push_random(150);
      // let the sender sit until every verdict is in
      if (s == 2) wait_drained();
      push_random(155);
      wait_drained();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
